// File: rtl/rot3d_pkg.sv
package rot3d_pkg;

   localparam int COORD_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int CORDIC_ITERS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
   localparam int ITER_W        = $clog2(ATAN_ENTRIES);

   localparam int ANGLE_W     = 18;
   localparam int ANGLE_SHIFT = 15;
   localparam int TRIG_FRAC   = 30;
   localparam int TRIG_W      = TRIG_FRAC + 2;
   localparam int XY_W        = 34;
   localparam int Z_W         = 34;

   localparam int CSR_DATA_W  = ANGLE_W;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_SELECT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE       = 1'b1;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   localparam logic [ANGLE_W-1:0] SNAP_LIMIT  = ANGLE_W'(51469);
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(32'h26DD3B6A);

   function automatic logic signed [Z_W-1:0] atan_lookup(input logic [ITER_W-1:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         default: v = 30'd0;
      endcase
      return signed'(Z_W'(v));
   endfunction

endpackage

// File: rtl/rot3d_if.sv
interface rot3d_req_if;
   import rot3d_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vertex_x;
   logic signed [COORD_WIDTH-1:0] vertex_y;
   logic signed [COORD_WIDTH-1:0] vertex_z;

   modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                   output ready);
endinterface

interface rot3d_rsp_if;
   import rot3d_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rotated_x;
   logic signed [COORD_WIDTH-1:0] rotated_y;
   logic signed [COORD_WIDTH-1:0] rotated_z;

   modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                   input ready);
   modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                   output ready);
endinterface

// File: rtl/axis_rotation_3d.sv
// axis_rotation_3d: rotates one vertex per transaction about the X or Y axis.
// req_chan carries vertex_x/y/z (signed Q8.8), rsp_chan returns rotated_x/y/z,
// saturated. Both use valid/ready; a transaction completes when both are high.
// The csr_ port writes axis_select (index 0) and angle (index 1, Q3.15 radians)
// at any edge with csr_write_enable high; write only while no vertex is in flight.
// Cosine and sine are formed once per angle write by an iterative CORDIC unit
// doing one micro-rotation per cycle over CORDIC_ITERS steps, or none when the
// angle snaps to +/- pi/2. req_chan.ready is low meanwhile.
// The vertex datapath is four register stages: input select, multiply, add and
// round, saturate into the output register. Throughput is one vertex per cycle
// while rsp_chan.ready is high and the CORDIC is idle.
// Reset (synchronous, active high) clears axis_select and angle to zero, empties
// the pipeline and starts the CORDIC for angle zero.
// When rsp_chan.ready is low, the output holds and the earlier stages keep
// filling until all four hold a vertex, then req_chan.ready drops; nothing is
// lost or repeated.
module axis_rotation_3d (
   input  logic                             clock,
   input  logic                             reset,
   rot3d_req_if.sink                        req_chan,
   rot3d_rsp_if.source                      rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [rot3d_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rot3d_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import rot3d_pkg::*;

   localparam int PROD_W = TRIG_W + COORD_WIDTH;
   localparam int SUM_W  = PROD_W + 1;
   localparam int SHR_W  = SUM_W - TRIG_FRAC;

   localparam logic signed [XY_W-1:0]   ONE_XY      = XY_W'(1) <<< TRIG_FRAC;
   localparam logic signed [XY_W-1:0]   NEG_ONE_XY  = -ONE_XY;
   localparam logic signed [TRIG_W-1:0] ONE_TRIG    = TRIG_W'(1) <<< TRIG_FRAC;
   localparam logic signed [TRIG_W-1:0] NEG_ONE_TRIG = -ONE_TRIG;
   localparam logic signed [SUM_W-1:0]  ROUND_BIAS  = SUM_W'(1) <<< (TRIG_FRAC - 1);
   localparam logic signed [SHR_W-1:0]  SAT_HI =
      {{(SHR_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SHR_W-1:0]  SAT_LO = ~SAT_HI;
   localparam logic [ITER_W-1:0]        LAST_ITER = ITER_W'(CORDIC_ITERS - 1);

   function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [XY_W-1:0] v);
      if (v > ONE_XY) return ONE_TRIG;
      else if (v < NEG_ONE_XY) return NEG_ONE_TRIG;
      else return v[TRIG_W-1:0];
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] round_sat(input logic signed [SUM_W-1:0] v);
      logic signed [SHR_W-1:0] q;
      q = SHR_W'(v >>> TRIG_FRAC);
      if (q > SAT_HI) return SAT_HI[COORD_WIDTH-1:0];
      else if (q < SAT_LO) return SAT_LO[COORD_WIDTH-1:0];
      else return q[COORD_WIDTH-1:0];
   endfunction

   // configuration registers
   logic                       axis_ff;
   logic signed [ANGLE_W-1:0]  angle_ff;
   logic                       angle_wr;

   assign angle_wr = csr_write_enable && (csr_index == REG_ANGLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff  <= AXIS_X;
         angle_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_AXIS_SELECT: axis_ff  <= csr_write_data[0];
            REG_ANGLE:       angle_ff <= csr_write_data[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // iterative cordic for cosine and sine of the angle
   logic                       start_ff, start_in;
   logic                       busy_ff, busy_in;
   logic [ITER_W-1:0]          iter_ff, iter_in;
   logic signed [XY_W-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic signed [Z_W-1:0]      cz_ff, cz_in;
   logic signed [TRIG_W-1:0]   c_ff, c_in, s_ff, s_in;
   logic signed [XY_W-1:0]     sh_x, sh_y, nx, ny;
   logic signed [Z_W-1:0]      nz, atan_val;
   logic [ANGLE_W-1:0]         angle_mag;
   logic                       trig_ready;

   assign angle_mag  = angle_ff[ANGLE_W-1] ? (~angle_ff + 1'b1) : angle_ff;
   assign trig_ready = !start_ff && !busy_ff;
   assign atan_val   = atan_lookup(iter_ff);
   assign sh_x       = cx_ff >>> iter_ff;
   assign sh_y       = cy_ff >>> iter_ff;

   always_comb begin
      if (!cz_ff[Z_W-1]) begin
         nx = cx_ff - sh_y;
         ny = cy_ff + sh_x;
         nz = cz_ff - atan_val;
      end else begin
         nx = cx_ff + sh_y;
         ny = cy_ff - sh_x;
         nz = cz_ff + atan_val;
      end
   end

   always_comb begin
      start_in = angle_wr;
      busy_in  = busy_ff;
      iter_in  = iter_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      c_in     = c_ff;
      s_in     = s_ff;
      priority if (start_ff) begin
         if (angle_mag >= SNAP_LIMIT) begin
            busy_in = 1'b0;
            c_in    = '0;
            s_in    = angle_ff[ANGLE_W-1] ? NEG_ONE_TRIG : ONE_TRIG;
         end else begin
            busy_in = 1'b1;
            iter_in = '0;
            cx_in   = CORDIC_GAIN;
            cy_in   = '0;
            cz_in   = Z_W'(angle_ff) <<< ANGLE_SHIFT;
         end
      end else if (busy_ff) begin
         cx_in   = nx;
         cy_in   = ny;
         cz_in   = nz;
         iter_in = iter_ff + 1'b1;
         if (iter_ff == LAST_ITER) begin
            busy_in = 1'b0;
            c_in    = clamp_trig(nx);
            s_in    = clamp_trig(ny);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         busy_ff  <= 1'b0;
         iter_ff  <= '0;
      end else begin
         start_ff <= start_in;
         busy_ff  <= busy_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      c_ff  <= c_in;
      s_ff  <= s_in;
   end

   // vertex pipeline
   logic                          v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic                          en1, en2, en3, out_en;
   logic signed [COORD_WIDTH-1:0] a1_ff, b1_ff, pass1_ff, pass2_ff, pass3_ff;
   logic signed [PROD_W-1:0]      p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [SUM_W-1:0]       r1_ff, r2_ff;
   logic signed [COORD_WIDTH-1:0] rx_ff, ry_ff, rz_ff, r1_sat, r2_sat;

   assign out_en = !out_valid_ff || rsp_chan.ready;
   assign en3    = !v3_ff || out_en;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;

   assign req_chan.ready = en1 && trig_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff        <= req_chan.valid && req_chan.ready;
         if (en2)    v2_ff        <= v1_ff;
         if (en3)    v3_ff        <= v2_ff;
         if (out_en) out_valid_ff <= v3_ff;
      end
   end

   assign r1_sat = round_sat(r1_ff);
   assign r2_sat = round_sat(r2_ff);

   always_ff @(posedge clock) begin
      if (en1) begin
         a1_ff    <= (axis_ff == AXIS_Y) ? req_chan.vertex_x : req_chan.vertex_y;
         b1_ff    <= req_chan.vertex_z;
         pass1_ff <= (axis_ff == AXIS_Y) ? req_chan.vertex_y : req_chan.vertex_x;
      end
      if (en2) begin
         p0_ff    <= c_ff * a1_ff;
         p1_ff    <= s_ff * b1_ff;
         p2_ff    <= s_ff * a1_ff;
         p3_ff    <= c_ff * b1_ff;
         pass2_ff <= pass1_ff;
      end
      if (en3) begin
         if (axis_ff == AXIS_Y) begin
            r1_ff <= SUM_W'(p0_ff) + SUM_W'(p1_ff) + ROUND_BIAS;
            r2_ff <= SUM_W'(p3_ff) - SUM_W'(p2_ff) + ROUND_BIAS;
         end else begin
            r1_ff <= SUM_W'(p0_ff) - SUM_W'(p1_ff) + ROUND_BIAS;
            r2_ff <= SUM_W'(p2_ff) + SUM_W'(p3_ff) + ROUND_BIAS;
         end
         pass3_ff <= pass2_ff;
      end
      if (out_en) begin
         if (axis_ff == AXIS_Y) begin
            rx_ff <= r1_sat;
            ry_ff <= pass3_ff;
         end else begin
            rx_ff <= pass3_ff;
            ry_ff <= r1_sat;
         end
         rz_ff <= r2_sat;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.rotated_x = rx_ff;
   assign rsp_chan.rotated_y = ry_ff;
   assign rsp_chan.rotated_z = rz_ff;

`ifndef NO_ASSERTIONS
   a_angle_write_blocks_input: assert property (@(posedge clock) disable iff (reset)
      angle_wr |=> !req_chan.ready)
      else $error("vertex accepted before cordic restart");

   a_iter_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (iter_ff <= LAST_ITER))
      else $error("cordic iteration count out of range");

   a_trig_bounded: assert property (@(posedge clock) disable iff (reset)
      trig_ready |-> (c_ff <= ONE_TRIG && c_ff >= NEG_ONE_TRIG &&
                      s_ff <= ONE_TRIG && s_ff >= NEG_ONE_TRIG))
      else $error("cosine or sine outside unit range");
`endif

endmodule
